### hdl/hmef_pkg.sv
`default_nettype none

package hmef_pkg;

  // Descriptor framing
  localparam logic [7:0] MinDescLen     = 8'd2;
  localparam logic [7:0] DescInterface  = 8'd4;
  localparam logic [7:0] DescEndpoint   = 8'd5;
  localparam logic [7:0] IfMinLen       = 8'd9;
  localparam logic [7:0] EpMinLen       = 8'd7;
  localparam logic [7:0] LastCapPos     = 8'd7;

  // Interface class codes
  localparam logic [7:0] ClassHid       = 8'd3;
  localparam logic [7:0] SubclassBoot   = 8'd1;
  localparam logic [7:0] ProtoKeyboard  = 8'd1;
  localparam logic [7:0] ProtoMouse     = 8'd2;
  localparam logic [7:0] ProtoNone      = 8'hFF;

  // Endpoint attribute codes
  localparam logic [7:0] EpDirIn        = 8'h80;
  localparam logic [7:0] EpXferMask     = 8'h03;

  // Interface scores
  localparam logic [1:0] ScoreNone      = 2'd0;
  localparam logic [1:0] ScoreOther     = 2'd1;
  localparam logic [1:0] ScoreBoot      = 2'd2;
  localparam logic [1:0] ScoreBootMouse = 2'd3;

  // Defaults reported when no endpoint is chosen
  localparam logic [15:0] DefPacketSize = 16'd8;
  localparam logic [7:0]  DefInterval   = 8'd10;

  localparam int unsigned CapBytes = 6;

  // Walk state of one descriptor set
  typedef struct packed {
    logic [7:0]                     byte_position;
    logic [7:0]                     descriptor_length;
    logic [7:0]                     descriptor_type;
    logic [CapBytes-1:0][7:0]       captured_bytes;
    logic                           walk_stopped;
    logic [1:0]                     current_score;
    logic [7:0]                     current_protocol;
    logic [7:0]                     current_interface;
    logic                           interface_valid;
    logic [1:0]                     best_score;
    logic [7:0]                     best_protocol;
    logic [7:0]                     best_interface;
    logic [7:0]                     best_endpoint;
    logic [15:0]                    best_packet_size;
    logic [7:0]                     best_interval;
  } hmef_walk_t;

  localparam hmef_walk_t WalkReset = '{
    byte_position:     8'd0,
    descriptor_length: 8'd0,
    descriptor_type:   8'd0,
    captured_bytes:    '0,
    walk_stopped:      1'b0,
    current_score:     ScoreNone,
    current_protocol:  8'd0,
    current_interface: 8'd0,
    interface_valid:   1'b0,
    best_score:        ScoreNone,
    best_protocol:     ProtoNone,
    best_interface:    8'd0,
    best_endpoint:     8'd0,
    best_packet_size:  DefPacketSize,
    best_interval:     DefInterval
  };

  // One result item
  typedef struct packed {
    logic        found;
    logic [7:0]  interface_number;
    logic [7:0]  endpoint_address;
    logic [15:0] max_packet_size;
    logic [7:0]  poll_interval;
    logic [7:0]  interface_protocol;
    logic [1:0]  match_score;
    logic        absolute_pointer;
  } hmef_result_t;

endpackage

`default_nettype wire

### hdl/hmef_walker.sv
`default_nettype none

module hmef_walker (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  last_byte,
  input  wire logic                  hypervisor_present,
  output logic                       res_valid,
  output hmef_pkg::hmef_result_t     res
);

  hmef_pkg::hmef_walk_t st_r;
  hmef_pkg::hmef_walk_t st_upd;
  hmef_pkg::hmef_walk_t st_nxt;
  logic                 finish;
  logic [2:0]           cap_idx;
  logic                 found;

  assign cap_idx = 3'(st_r.byte_position - 8'd2);

  // Walk one byte: frame by length, capture bytes 1..7, judge on the final byte
  always_comb begin
    st_upd = st_r;
    finish = 1'b0;
    if (!st_r.walk_stopped) begin
      if (st_r.byte_position == 8'd0) begin
        st_upd.descriptor_length = data_byte;
        if (data_byte < hmef_pkg::MinDescLen) begin
          st_upd.walk_stopped = 1'b1;
        end else begin
          st_upd.byte_position = 8'd1;
        end
      end else begin
        if (st_r.byte_position == 8'd1) begin
          st_upd.descriptor_type = data_byte;
        end else if (st_r.byte_position <= hmef_pkg::LastCapPos) begin
          st_upd.captured_bytes[cap_idx] = data_byte;
        end
        finish = ({1'b0, st_r.byte_position} + 9'd1) == {1'b0, st_r.descriptor_length};
        if (finish) begin
          st_upd.byte_position = 8'd0;
        end else begin
          st_upd.byte_position = st_r.byte_position + 8'd1;
        end
      end
    end

    // Descriptor complete
    if (finish) begin
      if (st_upd.descriptor_type == hmef_pkg::DescInterface &&
          st_r.descriptor_length >= hmef_pkg::IfMinLen) begin
        st_upd.current_protocol = st_upd.captured_bytes[5];
        st_upd.current_score    = hmef_pkg::ScoreNone;
        st_upd.interface_valid  = 1'b0;
        if (st_upd.captured_bytes[3] == hmef_pkg::ClassHid &&
            st_upd.captured_bytes[5] != hmef_pkg::ProtoKeyboard) begin
          st_upd.interface_valid   = 1'b1;
          st_upd.current_interface = st_upd.captured_bytes[0];
          if (st_upd.captured_bytes[4] == hmef_pkg::SubclassBoot &&
              st_upd.captured_bytes[5] == hmef_pkg::ProtoMouse) begin
            st_upd.current_score = hmef_pkg::ScoreBootMouse;
          end else if (st_upd.captured_bytes[4] == hmef_pkg::SubclassBoot) begin
            st_upd.current_score = hmef_pkg::ScoreBoot;
          end else begin
            st_upd.current_score = hmef_pkg::ScoreOther;
          end
        end
      end else if (st_upd.descriptor_type == hmef_pkg::DescEndpoint &&
                   st_r.descriptor_length >= hmef_pkg::EpMinLen &&
                   st_r.interface_valid && st_r.current_score != hmef_pkg::ScoreNone) begin
        // interrupt-IN endpoint of a strictly better interface
        if ((st_upd.captured_bytes[0] & hmef_pkg::EpDirIn) != 8'd0 &&
            (st_upd.captured_bytes[1] & hmef_pkg::EpXferMask) == hmef_pkg::EpXferMask &&
            st_r.current_score > st_r.best_score) begin
          st_upd.best_score       = st_r.current_score;
          st_upd.best_protocol    = st_r.current_protocol;
          st_upd.best_interface   = st_r.current_interface;
          st_upd.best_endpoint    = st_upd.captured_bytes[0];
          st_upd.best_packet_size = {st_upd.captured_bytes[3], st_upd.captured_bytes[2]};
          st_upd.best_interval    = st_upd.captured_bytes[4];
          if (st_r.current_score == hmef_pkg::ScoreBootMouse) begin
            st_upd.walk_stopped = 1'b1;
          end
        end
      end
    end
  end

  // Result from the state after this byte
  assign found = st_upd.best_score != hmef_pkg::ScoreNone;

  always_comb begin
    res.found              = found;
    res.interface_number   = found ? st_upd.best_interface : st_upd.current_interface;
    res.endpoint_address   = found ? st_upd.best_endpoint : 8'd0;
    res.max_packet_size    = found ? st_upd.best_packet_size : hmef_pkg::DefPacketSize;
    res.poll_interval      = found ? st_upd.best_interval : hmef_pkg::DefInterval;
    res.interface_protocol = found ? st_upd.best_protocol : hmef_pkg::ProtoNone;
    res.match_score        = st_upd.best_score;
    res.absolute_pointer   = found && st_upd.best_protocol != hmef_pkg::ProtoMouse &&
                             hypervisor_present;
  end

  assign res_valid = step && last_byte;

  // Last byte restarts the walk
  always_comb begin
    st_nxt = st_r;
    if (step) begin
      st_nxt = last_byte ? hmef_pkg::WalkReset : st_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= hmef_pkg::WalkReset;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Inside a descriptor the position stays below its length
  a_pos_in_desc: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.byte_position != 8'd0 |-> st_r.byte_position < st_r.descriptor_length)
    else $error("byte position beyond descriptor length");

  // A chosen endpoint is always an IN endpoint
  a_best_is_in: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.best_score != hmef_pkg::ScoreNone |-> st_r.best_endpoint[7])
    else $error("chosen endpoint is not IN");

  // The walk only stops on a short length or a boot mouse match
  a_stop_cause: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.walk_stopped |-> (st_r.best_score == hmef_pkg::ScoreBootMouse ||
                           st_r.descriptor_length < hmef_pkg::MinDescLen))
    else $error("walk stopped without cause");

  // After a result the walk is back at its start
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> st_r == hmef_pkg::WalkReset)
    else $error("walk state not cleared after last byte");

endmodule

`default_nettype wire

### hdl/hid_mouse_endpoint_finder.sv
// HID pointer endpoint finder.
// Input channel (in_valid/in_ready): one byte of a USB configuration descriptor
// set per item, with in_last_byte marking the final byte of the set.
// Result channel (out_valid/out_ready): one item per descriptor set, issued for
// the last byte, carrying the chosen interrupt-IN endpoint of the best HID
// pointer interface (or defaults when none was found).
// Config channel (cfg_valid/cfg_ready): writes hypervisor_present; always ready.
// Write it only while no set is in flight.
// Throughput: one byte per cycle, except while a last byte waits (see below); each
// byte is judged by compare logic between the input register and the
// walk/result registers.
// A result is loaded into the result register when its last byte leaves the
// input register, and shows at out_valid from that register.
// When the result register is full and out_ready is low, bytes other than a
// last byte still flow; a last byte waits in the input register and in_ready
// drops until the result is taken.
// Reset (rst_n low, synchronous) clears the walk, empties both registers and
// clears hypervisor_present.
`default_nettype none

module hid_mouse_endpoint_finder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_found,
  output logic [7:0]       out_interface_number,
  output logic [7:0]       out_endpoint_address,
  output logic [15:0]      out_max_packet_size,
  output logic [7:0]       out_poll_interval,
  output logic [7:0]       out_interface_protocol,
  output logic [1:0]       out_match_score,
  output logic             out_absolute_pointer,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_hypervisor_present
);

  logic                   hyp_r;
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic [7:0]             s1_data_r;
  logic                   s1_last_r;
  logic                   s1_go;
  logic                   res_valid;
  hmef_pkg::hmef_result_t res;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  hmef_pkg::hmef_result_t out_r;

  // Config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hyp_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      hyp_r <= cfg_hypervisor_present;
    end
  end

  // Input register: a last byte waits for room in the result register
  assign s1_go    = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  hmef_walker u_walker (
    .clk                (clk),
    .rst_n              (rst_n),
    .step               (s1_go),
    .data_byte          (s1_data_r),
    .last_byte          (s1_last_r),
    .hypervisor_present (hyp_r),
    .res_valid          (res_valid),
    .res                (res)
  );

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_found              = out_r.found;
  assign out_interface_number   = out_r.interface_number;
  assign out_endpoint_address   = out_r.endpoint_address;
  assign out_max_packet_size    = out_r.max_packet_size;
  assign out_poll_interval      = out_r.poll_interval;
  assign out_interface_protocol = out_r.interface_protocol;
  assign out_match_score        = out_r.match_score;
  assign out_absolute_pointer   = out_r.absolute_pointer;

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int DrainCycles = 6;
  localparam int CycleLimit  = 400000;
  localparam int RandBytes   = 100;

  // Clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  // Block inputs, all known from time zero
  logic       in_valid = 1'b0;
  logic [7:0] in_data_byte = 8'd0;
  logic       in_last_byte = 1'b0;
  logic       out_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_hypervisor_present = 1'b0;

  // Block outputs
  logic        in_ready;
  logic        out_valid;
  logic        out_found;
  logic [7:0]  out_interface_number;
  logic [7:0]  out_endpoint_address;
  logic [15:0] out_max_packet_size;
  logic [7:0]  out_poll_interval;
  logic [7:0]  out_interface_protocol;
  logic [1:0]  out_match_score;
  logic        out_absolute_pointer;
  logic        cfg_ready;

  hid_mouse_endpoint_finder u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_data_byte           (in_data_byte),
    .in_last_byte           (in_last_byte),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_found              (out_found),
    .out_interface_number   (out_interface_number),
    .out_endpoint_address   (out_endpoint_address),
    .out_max_packet_size    (out_max_packet_size),
    .out_poll_interval      (out_poll_interval),
    .out_interface_protocol (out_interface_protocol),
    .out_match_score        (out_match_score),
    .out_absolute_pointer   (out_absolute_pointer),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_hypervisor_present (cfg_hypervisor_present)
  );

  // Bookkeeping
  int   cycles = 0;
  int   errors = 0;
  int   bytes_sent = 0;
  int   sets_done = 0;
  int   found_sets = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic drv_busy = 1'b0;

  logic [7:0]             set_bytes[$];
  hmef_pkg::hmef_result_t pending_results[$];

  // Shadow of the descriptor walk
  logic            hv_shadow = 1'b0;
  logic [7:0]      w_pos = 8'd0;
  logic [7:0]      w_len = 8'd0;
  logic [7:0]      w_type = 8'd0;
  logic [5:0][7:0] w_cap = '0;
  logic            w_stop = 1'b0;
  logic [1:0]      w_cur_score = hmef_pkg::ScoreNone;
  logic [7:0]      w_cur_proto = 8'd0;
  logic [7:0]      w_cur_if = 8'd0;
  logic            w_if_ok = 1'b0;
  logic [1:0]      w_best_score = hmef_pkg::ScoreNone;
  logic [7:0]      w_best_proto = hmef_pkg::ProtoNone;
  logic [7:0]      w_best_if = 8'd0;
  logic [7:0]      w_best_ep = 8'd0;
  logic [15:0]     w_best_mps = hmef_pkg::DefPacketSize;
  logic [7:0]      w_best_ival = hmef_pkg::DefInterval;

  always @(posedge clk) cycles <= cycles + 1;

  // Receiver: random backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic walk_clear();
    w_pos = 8'd0;
    w_len = 8'd0;
    w_type = 8'd0;
    w_cap = '0;
    w_stop = 1'b0;
    w_cur_score = hmef_pkg::ScoreNone;
    w_cur_proto = 8'd0;
    w_cur_if = 8'd0;
    w_if_ok = 1'b0;
    w_best_score = hmef_pkg::ScoreNone;
    w_best_proto = hmef_pkg::ProtoNone;
    w_best_if = 8'd0;
    w_best_ep = 8'd0;
    w_best_mps = hmef_pkg::DefPacketSize;
    w_best_ival = hmef_pkg::DefInterval;
  endtask

  // Judge a descriptor once its final byte is in
  task automatic walk_close_desc();
    if (w_type == hmef_pkg::DescInterface && w_len >= hmef_pkg::IfMinLen) begin
      w_cur_proto = w_cap[5];
      w_cur_score = hmef_pkg::ScoreNone;
      w_if_ok = 1'b0;
      if (w_cap[3] == hmef_pkg::ClassHid && w_cap[5] != hmef_pkg::ProtoKeyboard) begin
        w_if_ok = 1'b1;
        w_cur_if = w_cap[0];
        if (w_cap[4] == hmef_pkg::SubclassBoot && w_cap[5] == hmef_pkg::ProtoMouse)
          w_cur_score = hmef_pkg::ScoreBootMouse;
        else if (w_cap[4] == hmef_pkg::SubclassBoot) w_cur_score = hmef_pkg::ScoreBoot;
        else w_cur_score = hmef_pkg::ScoreOther;
      end
    end else if (w_type == hmef_pkg::DescEndpoint && w_len >= hmef_pkg::EpMinLen &&
                 w_if_ok && w_cur_score != hmef_pkg::ScoreNone) begin
      if ((w_cap[0] & hmef_pkg::EpDirIn) != 8'd0 &&
          (w_cap[1] & hmef_pkg::EpXferMask) == hmef_pkg::EpXferMask &&
          w_cur_score > w_best_score) begin
        w_best_score = w_cur_score;
        w_best_proto = w_cur_proto;
        w_best_if = w_cur_if;
        w_best_ep = w_cap[0];
        w_best_mps = {w_cap[3], w_cap[2]};
        w_best_ival = w_cap[4];
        if (w_best_score == hmef_pkg::ScoreBootMouse) w_stop = 1'b1;
      end
    end
  endtask

  // Advance the shadow walk by one accepted byte
  task automatic walk_byte(input logic [7:0] d, input logic last);
    hmef_pkg::hmef_result_t r;
    logic                   hit;
    if (!w_stop) begin
      if (w_pos == 8'd0) begin
        w_len = d;
        if (d < hmef_pkg::MinDescLen) w_stop = 1'b1;
        else w_pos = 8'd1;
      end else begin
        if (w_pos == 8'd1) w_type = d;
        else if (w_pos <= hmef_pkg::LastCapPos) w_cap[w_pos - 8'd2] = d;
        if (int'(w_pos) + 1 == int'(w_len)) begin
          walk_close_desc();
          w_pos = 8'd0;
        end else begin
          w_pos = w_pos + 8'd1;
        end
      end
    end
    if (last) begin
      hit = (w_best_score != hmef_pkg::ScoreNone);
      r.found = hit;
      r.interface_number = hit ? w_best_if : w_cur_if;
      r.endpoint_address = hit ? w_best_ep : 8'd0;
      r.max_packet_size = hit ? w_best_mps : hmef_pkg::DefPacketSize;
      r.poll_interval = hit ? w_best_ival : hmef_pkg::DefInterval;
      r.interface_protocol = hit ? w_best_proto : hmef_pkg::ProtoNone;
      r.match_score = w_best_score;
      r.absolute_pointer = hit && w_best_proto != hmef_pkg::ProtoMouse && hv_shadow;
      pending_results.push_back(r);
      if (hit) found_sets++;
      walk_clear();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) walk_byte(in_data_byte, in_last_byte);
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR @%0d: %s got %0h expected %0h", cycles, what, got, want);
    errors++;
  endtask

  // Compare one result item with the oldest prediction
  task automatic check_result();
    hmef_pkg::hmef_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending, found", out_found, 0);
    end else begin
      want = pending_results.pop_front();
      if (out_found !== want.found)
        report_mismatch("found", out_found, want.found);
      if (out_interface_number !== want.interface_number)
        report_mismatch("interface_number", out_interface_number, want.interface_number);
      if (out_endpoint_address !== want.endpoint_address)
        report_mismatch("endpoint_address", out_endpoint_address, want.endpoint_address);
      if (out_max_packet_size !== want.max_packet_size)
        report_mismatch("max_packet_size", out_max_packet_size, want.max_packet_size);
      if (out_poll_interval !== want.poll_interval)
        report_mismatch("poll_interval", out_poll_interval, want.poll_interval);
      if (out_interface_protocol !== want.interface_protocol)
        report_mismatch("interface_protocol", out_interface_protocol,
                        want.interface_protocol);
      if (out_match_score !== want.match_score)
        report_mismatch("match_score", out_match_score, want.match_score);
      if (out_absolute_pointer !== want.absolute_pointer)
        report_mismatch("absolute_pointer", out_absolute_pointer, want.absolute_pointer);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
  end

  // Send one byte, with a random gap in front
  task automatic send_byte(input logic [7:0] d, input logic l);
    int gap;
    gap = 0;
    if (send_idle_pct > 0) begin
      while ($urandom_range(99) < send_idle_pct) gap++;
    end
    if (gap > 0) begin
      if (drv_busy) begin
        in_valid <= 1'b0;
        drv_busy = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= l;
    drv_busy = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Send the built set; the final byte carries the last flag
  task automatic send_set();
    for (int i = 0; i < set_bytes.size(); i++) send_byte(set_bytes[i], i == set_bytes.size() - 1);
    set_bytes.delete();
    sets_done++;
  endtask

  // Stop sending and wait until every predicted result is out
  task automatic wait_for_drain();
    if (drv_busy) begin
      in_valid <= 1'b0;
      drv_busy = 1'b0;
    end
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_hypervisor(input logic v);
    cfg_valid <= 1'b1;
    cfg_hypervisor_present <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    hv_shadow = v;
    cfg_valid <= 1'b0;
  endtask

  // Descriptor builders; bytes past the captured window are random
  task automatic push_desc(input logic [7:0] len, input logic [7:0] typ,
                           input logic [5:0][7:0] body);
    set_bytes.push_back(len);
    for (int i = 1; i < int'(len); i++) begin
      if (i == 1) set_bytes.push_back(typ);
      else if (i <= 7) set_bytes.push_back(body[i - 2]);
      else set_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic push_iface(input logic [7:0] len, input logic [7:0] num,
                            input logic [7:0] cls, input logic [7:0] sub,
                            input logic [7:0] proto);
    logic [5:0][7:0] b;
    b[0] = num;
    b[1] = 8'($urandom);
    b[2] = 8'($urandom);
    b[3] = cls;
    b[4] = sub;
    b[5] = proto;
    push_desc(len, hmef_pkg::DescInterface, b);
  endtask

  task automatic push_ep(input logic [7:0] len, input logic [7:0] addr,
                         input logic [7:0] attr, input logic [15:0] mps,
                         input logic [7:0] ival);
    logic [5:0][7:0] b;
    b[0] = addr;
    b[1] = attr;
    b[2] = mps[7:0];
    b[3] = mps[15:8];
    b[4] = ival;
    b[5] = 8'($urandom);
    push_desc(len, hmef_pkg::DescEndpoint, b);
  endtask

  function automatic logic [7:0] pick_code(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c);
    case ($urandom_range(3))
      0: pick_code = a;
      1: pick_code = b;
      2: pick_code = c;
      default: pick_code = 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_len(input int nominal);
    case ($urandom_range(7))
      0: pick_len = 8'($urandom_range(2, nominal - 1));
      1: pick_len = 8'($urandom_range(nominal + 1, nominal + 6));
      default: pick_len = 8'(nominal);
    endcase
  endfunction

  // One random descriptor set: mostly well formed, some noise and breakage
  task automatic build_random_set();
    int              n;
    logic [5:0][7:0] b;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 20);
      repeat (n) set_bytes.push_back(8'($urandom));
    end else begin
      n = $urandom_range(1, 5);
      repeat (n) begin
        case ($urandom_range(9))
          0, 1, 2, 3:
            push_iface(pick_len(9), 8'($urandom),
                       ($urandom_range(4) == 0) ? 8'($urandom) : hmef_pkg::ClassHid,
                       pick_code(8'd0, hmef_pkg::SubclassBoot, 8'd2),
                       pick_code(8'd0, hmef_pkg::ProtoKeyboard, hmef_pkg::ProtoMouse));
          4, 5, 6, 7:
            push_ep(pick_len(7),
                    ($urandom_range(4) == 0) ? 8'($urandom) :
                                               (hmef_pkg::EpDirIn | 8'($urandom_range(15))),
                    ($urandom_range(4) == 0) ? 8'($urandom) : {6'($urandom), 2'b11},
                    16'($urandom), 8'($urandom));
          8: begin
            b = 48'({$urandom, $urandom});
            push_desc(8'($urandom_range(2, 12)), 8'($urandom), b);
          end
          default: begin
            b = 48'({$urandom, $urandom});
            if ($urandom_range(9) == 0) push_desc(8'($urandom_range(200, 255)), 8'($urandom), b);
            else push_desc(8'($urandom_range(1)), 8'd0, b);
          end
        endcase
      end
      // cut the set short, or leave trailing bytes
      if ($urandom_range(7) == 0) begin
        n = $urandom_range(1, set_bytes.size());
        while (set_bytes.size() > n) void'(set_bytes.pop_back());
      end else if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 4)) set_bytes.push_back(8'($urandom));
      end
    end
  endtask

  // A one-byte set with a zero length byte, and a set that opens with a length byte of one, give the defaults
  task automatic test_defaults();
    write_hypervisor(1'b0);
    set_bytes.push_back(8'h00);
    send_set();
    set_bytes.push_back(8'h01);
    push_iface(8'd9, 8'd5, hmef_pkg::ClassHid, hmef_pkg::SubclassBoot, hmef_pkg::ProtoMouse);
    push_ep(8'd7, 8'h81, 8'h03, 16'h0040, 8'd1);
    send_set();
  endtask

  // Boot mouse ends the walk; trailing bytes are ignored
  task automatic test_boot_mouse();
    logic [5:0][7:0] b;
    wait_for_drain();
    write_hypervisor(1'b1);
    push_iface(8'd9, 8'hFF, hmef_pkg::ClassHid, hmef_pkg::SubclassBoot, hmef_pkg::ProtoMouse);
    push_ep(8'd7, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
    set_bytes.push_back(8'hFF);
    set_bytes.push_back(8'h00);
    send_set();
    b = '0;
    push_desc(8'd9, 8'd2, b);
    push_iface(8'd9, 8'd0, hmef_pkg::ClassHid, hmef_pkg::SubclassBoot, hmef_pkg::ProtoMouse);
    push_ep(8'd7, 8'h80, 8'h03, 16'h0000, 8'h00);
    send_set();
  endtask

  // A strictly better interface replaces the choice, a worse one does not
  task automatic test_scoring();
    push_iface(8'd9, 8'd1, hmef_pkg::ClassHid, 8'd0, 8'd0);
    push_ep(8'd7, 8'h82, 8'h03, 16'h0040, 8'd4);
    push_iface(8'd12, 8'd2, hmef_pkg::ClassHid, hmef_pkg::SubclassBoot, 8'd0);
    push_ep(8'd10, 8'h83, 8'h07, 16'h1208, 8'd10);
    push_ep(8'd7, 8'h85, 8'h03, 16'h0010, 8'd2);
    push_iface(8'd9, 8'd3, hmef_pkg::ClassHid, 8'd5, 8'd7);
    push_ep(8'd7, 8'h84, 8'h03, 16'h0020, 8'd3);
    send_set();
  endtask

  // Keyboard, non-HID, short, OUT, bulk and cut-off descriptors are not taken
  task automatic test_rejects();
    wait_for_drain();
    write_hypervisor(1'b0);
    push_ep(8'd7, 8'h81, 8'h03, 16'h0008, 8'd1);
    push_iface(8'd9, 8'd1, hmef_pkg::ClassHid, hmef_pkg::SubclassBoot,
               hmef_pkg::ProtoKeyboard);
    push_ep(8'd7, 8'h81, 8'h03, 16'h0008, 8'd1);
    push_iface(8'd9, 8'd2, 8'h08, 8'h06, 8'h50);
    push_ep(8'd7, 8'h82, 8'h03, 16'h0008, 8'd1);
    push_iface(8'd8, 8'd3, hmef_pkg::ClassHid, hmef_pkg::SubclassBoot, hmef_pkg::ProtoMouse);
    push_ep(8'd7, 8'h83, 8'h03, 16'h0008, 8'd1);
    push_iface(8'd9, 8'd4, hmef_pkg::ClassHid, 8'd0, 8'd0);
    push_ep(8'd6, 8'h84, 8'h03, 16'h0008, 8'd1);
    push_ep(8'd7, 8'h04, 8'h03, 16'h0008, 8'd1);
    push_ep(8'd7, 8'h84, 8'h02, 16'h0008, 8'd1);
    push_ep(8'd7, 8'h85, 8'h03, 16'h0008, 8'd1);
    void'(set_bytes.pop_back());
    void'(set_bytes.pop_back());
    send_set();
  endtask

  task automatic run_random_phase(input int sidle, input int ridle, input logic hv);
    int start;
    int sets;
    wait_for_drain();
    write_hypervisor(hv);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    start = bytes_sent;
    sets = 0;
    while (bytes_sent - start < RandBytes) begin
      build_random_set();
      send_set();
      sets++;
      if (sets % 8 == 0) wait_for_drain();
    end
  endtask

  // Timeout
  initial begin
    while (cycles < CycleLimit) @(posedge clk);
    $display("Timeout after %0d cycles, %0d results still pending", cycles,
             pending_results.size());
    $display("FAIL");
    $finish;
  end

  // Main sequence
  initial begin
    send_idle_pct = 19;
    recv_idle_pct = 79;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults();
    test_boot_mouse();
    test_scoring();
    test_rejects();
    run_random_phase(19, 79, 1'b1);
    run_random_phase(79, 19, 1'b0);
    run_random_phase(0, 0, 1'b1);

    wait_for_drain();
    if (pending_results.size() != 0)
      report_mismatch("results never seen, count", pending_results.size(), 0);
    $display("Covered %0d descriptor sets in %0d bytes, %0d of them with an endpoint chosen",
             sets_done, bytes_sent, found_sets);
    $display("Hypervisor flag set and clear, under three sender/receiver stall mixes");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
